// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the template correlator
// Function codes, sequencer states and the coefficient fraction width.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int QBITS = 14;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SIGNAL  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MATH,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/ptc_serial_mac.sv =====
// ----------------------------------------------------------------------------
// ptc_serial_mac: bit-serial signed multiply
// Shift-and-add multiply of two signed values, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ptc_serial_mac #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic signed [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0]           count;
  logic                    busy;
  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0]           mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        acc   <= '0;
        mcand <= (AW+BW)'(a);
        mplier <= b;
      end else if (busy) begin
        // top bit of a signed multiplier carries negative weight
        if (mplier[0]) begin
          if (count == CW'(BW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        count  <= count + 1'b1;
        if (count == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

// ===== rtl/ptc_isqrt.sv =====
// ----------------------------------------------------------------------------
// ptc_isqrt: iterative floor square root
// Result bits are settled most significant first, restoring method; a start while busy restarts the root.
// ----------------------------------------------------------------------------
module ptc_isqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   value,
  output logic           done,
  output logic [W/2-1:0] root
);

  localparam int CW = $clog2(W/2 + 1);

  logic [W-1:0]   rem;
  logic [W-1:0]   res;
  logic [W-1:0]   bitv;
  logic [CW-1:0]  count;
  logic           busy;
  logic [W-1:0]   trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= value;
        res   <= '0;
        bitv  <= W'(1) << (W - 2);
        count <= '0;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv  <= bitv >> 2;
        count <= count + 1'b1;
        if (count == CW'(W/2 - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[W/2-1:0];

endmodule

// ===== rtl/ptc_divider.sv =====
// ----------------------------------------------------------------------------
// ptc_divider: restoring divider, one quotient bit per cycle
// Unsigned quotient of num by den, den nonzero.
// ----------------------------------------------------------------------------
module ptc_divider #(
  parameter int NW = 80,
  parameter int DW = 66
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]    rem;
  logic [NW-1:0]  q;
  logic [DW-1:0]  d;
  logic [CW-1:0]  count;
  logic           busy;
  logic [DW:0]    shifted;

  assign shifted = {rem[DW-1:0], q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        q     <= num;
        d     <= den;
        count <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, d}) begin
          rem <= shifted - {1'b0, d};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NW-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

// ===== rtl/pearson_template_correlator_core.sv =====
// ----------------------------------------------------------------------------
// pearson_template_correlator_core: sliding Pearson correlation
// Template and signal ring in memories, bit-serial products, iterative
// square roots and division produce one Q1.14 coefficient per window.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        input      in_valid, in_ready, func, sample
// out       output     out_valid, out_ready, coefficient, zero_variance
// cfg       input      cfg_we, cfg_wdata (template_length)
//
// A load, restart, ignored or no-result signal item leaves the block idle.
// A signal item with a result walks L taps (three RW-bit serial multiplies
// per tap, RW = 40 at the default widths), then six variance products and,
// unless a variance is zero, two square roots, the denominator product and
// the division. Reset is synchronous; no clearing pass. A result waits in
// the output register while items are still taken; the next result holds
// the block until that register frees.
// ----------------------------------------------------------------------------
module pearson_template_correlator_core
  import ptc_pkg::*;
#(
  parameter int MAX_TEMPLATE = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            coefficient,
  output logic                          zero_variance,
  input  logic                          cfg_we,
  input  logic [6:0]                    cfg_wdata
);

  localparam int AW  = $clog2(MAX_TEMPLATE);
  localparam int LW  = $clog2(MAX_TEMPLATE + 1);
  localparam int PW  = 2 * SAMPLE_BITS;
  localparam int SW  = SAMPLE_BITS + LW;     // sum width
  localparam int QW  = PW + LW;              // sum of squares width
  localparam int VW  = 2 * QW + 2;           // variance width (even)
  localparam int RW  = VW / 2;
  localparam int DW  = 2 * RW;
  localparam int NW  = VW + QBITS + 2;

  typedef enum logic [3:0] {
    MS_DOT, MS_TT, MS_WW, MS_LD, MS_SWST, MS_LTT, MS_STST, MS_LWW, MS_SWSW,
    MS_SQT, MS_SQW, MS_DEN, MS_DIV, MS_DONE
  } mstep_t;

  logic [6:0]             template_length;
  logic [SAMPLE_BITS-1:0] tmem [MAX_TEMPLATE];
  logic [SAMPLE_BITS-1:0] wmem [MAX_TEMPLATE];
  logic [AW-1:0]          ring_head;
  logic [LW-1:0]          fill_count;
  logic [LW-1:0]          load_index;
  logic [LW-1:0]          len;

  state_t state, state_next;
  mstep_t mstep;

  logic [LW-1:0]                k;
  logic signed [SAMPLE_BITS-1:0] t_q, w_q;
  logic signed [QW-1:0] dot, stt, sww;
  logic signed [SW-1:0] st, sw;
  logic signed [VW-1:0] num, vt, vw, tmp;
  logic [RW-1:0]        rt, rw;
  logic                 zv;
  logic [15:0]          coef_q;
  logic [1:0]           sub;

  // shared serial multiplier, operands up to VW/2 bits
  logic                     m_start, m_done;
  logic signed [RW-1:0]     m_a, m_b;
  logic signed [2*RW-1:0]   m_p;
  logic                     s_start, s_done;
  logic [VW-1:0]            s_val;
  logic [RW-1:0]            s_root;
  logic                     d_start, d_done;
  logic [NW-1:0]            d_num, d_quo;
  logic [DW-1:0]            d_den;
  logic [DW-1:0]            den;
  logic [NW-1:0]            mag;

  ptc_serial_mac #(.AW(RW), .BW(RW)) u_mac (
    .clk, .rst, .start(m_start), .a(m_a), .b(m_b), .done(m_done), .product(m_p)
  );
  ptc_isqrt #(.W(VW)) u_sqrt (
    .clk, .rst, .start(s_start), .value(s_val), .done(s_done), .root(s_root)
  );
  ptc_divider #(.NW(NW), .DW(DW)) u_div (
    .clk, .rst, .start(d_start), .num(d_num), .den(d_den), .done(d_done), .quo(d_quo)
  );

  always_comb begin
    if (template_length == 7'd0) len = LW'(1);
    else if (32'(template_length) > MAX_TEMPLATE) len = LW'(MAX_TEMPLATE);
    else len = LW'(template_length);
  end

  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  // oldest window entry lines up with tap 0; wrap at the ring depth
  logic [LW:0]   wsum;
  logic [AW-1:0] widx;
  assign wsum = (LW+1)'(ring_head) + (LW+1)'(MAX_TEMPLATE) - (LW+1)'(len) + (LW+1)'(k);
  assign widx = (32'(wsum) >= MAX_TEMPLATE) ? AW'(32'(wsum) - MAX_TEMPLATE) : AW'(wsum);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func_t'(func) == FUNC_SIGNAL &&
            32'(fill_count) + 1 >= 32'(len)) state_next = ST_READ;
      end
      ST_READ: state_next = ST_ACC;
      ST_ACC:  if (sub == 2'd3) state_next = (k == len) ? ST_MATH : ST_READ;
      ST_MATH: if (mstep == MS_DONE) state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (mstep)
      MS_DOT:  begin m_a = RW'(t_q); m_b = RW'(w_q); end
      MS_TT:   begin m_a = RW'(t_q); m_b = RW'(t_q); end
      MS_WW:   begin m_a = RW'(w_q); m_b = RW'(w_q); end
      MS_LD:   begin m_a = RW'(signed'({1'b0, len})); m_b = RW'(dot); end
      MS_SWST: begin m_a = RW'(sw); m_b = RW'(st); end
      MS_LTT:  begin m_a = RW'(signed'({1'b0, len})); m_b = RW'(stt); end
      MS_STST: begin m_a = RW'(st); m_b = RW'(st); end
      MS_LWW:  begin m_a = RW'(signed'({1'b0, len})); m_b = RW'(sww); end
      MS_SWSW: begin m_a = RW'(sw); m_b = RW'(sw); end
      MS_DEN:  begin m_a = signed'(rt); m_b = signed'(rw); end
      default: ;
    endcase
  end

  assign s_val = (mstep == MS_SQT) ? vt : vw;
  assign d_den = {den[DW-2:0], 1'b0};
  assign mag   = (num < 0) ? NW'(-num) : NW'(num);
  assign d_num = (mag << (QBITS + 1)) + NW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      template_length <= 7'd64;
      ring_head       <= '0;
      fill_count      <= '0;
      load_index      <= '0;
      m_start <= 1'b0;
      s_start <= 1'b0;
      d_start <= 1'b0;
      mstep   <= MS_DOT;
      sub     <= '0;
      k       <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      m_start <= 1'b0;
      s_start <= 1'b0;
      d_start <= 1'b0;
      if (cfg_we) template_length <= cfg_wdata;
      // hand the finished result to the output register
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        coefficient   <= coef_q;
        zero_variance <= zv;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        unique case (func_t'(func))
          FUNC_RESTART: begin
            ring_head  <= '0;
            fill_count <= '0;
            load_index <= '0;
          end
          FUNC_LOAD: if (load_index < len) begin
            tmem[load_index[AW-1:0]] <= sample;
            load_index <= load_index + 1'b1;
          end
          FUNC_SIGNAL: begin
            wmem[ring_head] <= sample;
            ring_head <= (32'(ring_head) == MAX_TEMPLATE - 1) ? '0 : ring_head + 1'b1;
            if (32'(fill_count) < MAX_TEMPLATE) fill_count <= fill_count + 1'b1;
            k <= '0;
            dot <= '0; stt <= '0; sww <= '0; st <= '0; sw <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        ST_READ: begin
          t_q <= (k < load_index) ? tmem[k[AW-1:0]] : '0;
          w_q <= wmem[widx];
          mstep <= MS_DOT;
          sub <= '0;
          m_start <= 1'b1;
        end
        ST_ACC: begin
          if (m_done) begin
            unique case (sub)
              2'd0: begin dot <= dot + QW'(m_p); mstep <= MS_TT; m_start <= 1'b1; end
              2'd1: begin stt <= stt + QW'(m_p); mstep <= MS_WW; m_start <= 1'b1; end
              2'd2: begin
                sww <= sww + QW'(m_p);
                st <= st + SW'(t_q);
                sw <= sw + SW'(w_q);
                k <= k + 1'b1;
              end
              default: ;
            endcase
            sub <= sub + 1'b1;
          end else if (sub == 2'd3) begin
            sub <= '0;
            if (k == len) begin
              mstep <= MS_LD;
              m_start <= 1'b1;
            end
          end
        end
        ST_MATH: begin
          unique case (mstep)
            MS_LD:   if (m_done) begin tmp <= VW'(m_p); mstep <= MS_SWST; m_start <= 1'b1; end
            MS_SWST: if (m_done) begin num <= tmp - VW'(m_p); mstep <= MS_LTT; m_start <= 1'b1; end
            MS_LTT:  if (m_done) begin tmp <= VW'(m_p); mstep <= MS_STST; m_start <= 1'b1; end
            MS_STST: if (m_done) begin vt <= tmp - VW'(m_p); mstep <= MS_LWW; m_start <= 1'b1; end
            MS_LWW:  if (m_done) begin tmp <= VW'(m_p); mstep <= MS_SWSW; m_start <= 1'b1; end
            MS_SWSW: if (m_done) begin
              vw <= tmp - VW'(m_p);
              if (vt <= 0 || tmp - VW'(m_p) <= 0) begin
                zv <= 1'b1;
                coef_q <= '0;
                mstep <= MS_DONE;
              end else begin
                zv <= 1'b0;
                mstep <= MS_SQT;
                s_start <= 1'b1;
              end
            end
            MS_SQT: if (s_done) begin rt <= s_root; mstep <= MS_SQW; s_start <= 1'b1; end
            MS_SQW: if (s_done) begin rw <= s_root; mstep <= MS_DEN; m_start <= 1'b1; end
            MS_DEN: if (m_done) begin den <= DW'(m_p); mstep <= MS_DIV; d_start <= 1'b1; end
            MS_DIV: if (d_done) begin
              // clamp to +1.0, then apply sign
              if (d_quo > NW'(1 << QBITS))
                coef_q <= (num < 0) ? 16'(-(1 << QBITS)) : 16'(1 << QBITS);
              else
                coef_q <= (num < 0) ? 16'(-d_quo) : 16'(d_quo);
              mstep <= MS_DONE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient))
    else $error("result changed while stalled");
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_valid && !out_ready |=> state == ST_OUT)
    else $error("result overwrote a waiting result");
  a_zero_coef: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_variance |-> coefficient == 16'd0)
    else $error("zero variance with nonzero coefficient");

endmodule

// ===== test/pearson_template_correlator_core_test.sv =====
// ----------------------------------------------------------------------------
// pearson_template_correlator_core_test: self-checking regression
// Loads templates and streams signal samples through the correlator under
// several template lengths, predicts every coefficient in exact integer
// arithmetic and compares each result in order, with random idling on both
// channels.
// ----------------------------------------------------------------------------
class corr_scoreboard;
  localparam int MAXT = 64;
  localparam int QONE = 16384;

  logic signed [15:0] tmpl [MAXT];
  logic signed [15:0] ring [MAXT];
  int unsigned head, filled, load_idx, length_reg;
  logic signed [15:0] exp_coef [$];
  bit exp_zv [$];
  int mismatches, results_seen;

  function void clear_stream();
    head = 0;
    filled = 0;
    load_idx = 0;
  endfunction

  function void set_length(logic [6:0] v);
    length_reg = v;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function void note_item(ptc_pkg::func_t f, logic signed [15:0] s);
    int unsigned taps, wi;
    longint dot, st, stt, sw, sww, t, w, num, vt, vw;
    longint unsigned den, mag, q;
    taps = (length_reg == 0) ? 1 : ((length_reg > MAXT) ? MAXT : length_reg);
    case (f)
      ptc_pkg::FUNC_RESTART: clear_stream();
      ptc_pkg::FUNC_LOAD: begin
        if (load_idx < taps) begin
          tmpl[load_idx] = s;
          load_idx++;
        end
      end
      ptc_pkg::FUNC_SIGNAL: begin
        ring[head] = s;
        head = (head + 1) % MAXT;
        if (filled < MAXT) filled++;
        if (filled >= taps) begin
          dot = 0; st = 0; stt = 0; sw = 0; sww = 0;
          for (int k = 0; k < taps; k++) begin
            wi = (head + MAXT - taps + k) % MAXT;
            w = ring[wi];
            t = (k < load_idx) ? longint'(tmpl[k]) : 0;
            dot += t * w;
            st += t;
            stt += t * t;
            sw += w;
            sww += w * w;
          end
          num = taps * dot - sw * st;
          vt = taps * stt - st * st;
          vw = taps * sww - sw * sw;
          if (vt <= 0 || vw <= 0) begin
            exp_coef.push_back(16'sd0);
            exp_zv.push_back(1'b1);
          end else begin
            den = floor_sqrt(vt) * floor_sqrt(vw);
            mag = (num < 0) ? -num : num;
            q = (2 * QONE * mag + den) / (2 * den);
            if (q > QONE) q = QONE;
            exp_coef.push_back((num < 0) ? -16'(q) : 16'(q));
            exp_zv.push_back(1'b0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic signed [15:0] c, logic zv);
    results_seen++;
    if (exp_coef.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: coef %0d zv %0b", c, zv);
      return;
    end
    if (c !== exp_coef[0] || zv !== exp_zv[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected coef %0d zv %0b, got coef %0d zv %0b",
                 exp_coef[0], exp_zv[0], c, zv);
    end
    void'(exp_coef.pop_front());
    void'(exp_zv.pop_front());
  endfunction
endclass

module pearson_template_correlator_core_test;
  import ptc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_NONE;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] coefficient;
  logic zero_variance;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  corr_scoreboard sb = new();
  bit quiet_tail = 0;
  int unsigned items_sent = 0;

  pearson_template_correlator_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .coefficient(coefficient), .zero_variance(zero_variance),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver with random stall bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(coefficient, zero_variance);
      if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays up after an accept until the next item or an idle replaces it
  task automatic send_item(func_t f, logic signed [15:0] s);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_item(f, s);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_coef.size() != 0) @(posedge clk);
    // a non-result item may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(v);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // restart, load a template of the given length, then stream signal samples
  task automatic run_sequence(int unsigned taps, int unsigned nsig);
    send_item(FUNC_RESTART, 16'($urandom));
    for (int k = 0; k < taps; k++) send_item(FUNC_LOAD, rand_sample());
    for (int k = 0; k < nsig; k++) send_item(FUNC_SIGNAL, rand_sample());
  endtask

  initial begin
    int unsigned lens [6] = '{1, 2, 3, 5, 8, 64};
    int unsigned taps;
    sb.set_length(7'd64);
    sb.clear_stream();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short template, extremes, constant signal, partial load
    write_length(7'd4);
    send_item(FUNC_LOAD, 16'sh7fff);
    send_item(FUNC_LOAD, 16'sh8000);
    send_item(FUNC_LOAD, 16'sd1);
    send_item(FUNC_LOAD, -16'sd1);
    send_item(FUNC_LOAD, 16'sd99);           // beyond length, ignored
    send_item(FUNC_SIGNAL, 16'sh7fff);
    send_item(FUNC_SIGNAL, 16'sh8000);
    send_item(FUNC_SIGNAL, 16'sd1);
    send_item(FUNC_SIGNAL, -16'sd1);          // perfect match
    send_item(FUNC_SIGNAL, 16'sh7fff);
    send_item(FUNC_NONE, 16'sh5a5a);          // ignored
    send_item(FUNC_RESTART, 16'sh0);
    send_item(FUNC_LOAD, 16'sd5);             // partially loaded template
    for (int k = 0; k < 5; k++) send_item(FUNC_SIGNAL, 16'sd7); // flat window
    write_length(7'd0);                       // acts as one tap: zero variance
    send_item(FUNC_SIGNAL, -16'sd3);
    write_length(7'd127);                     // clamps to 64
    send_item(FUNC_RESTART, 16'shffff);
    send_item(FUNC_SIGNAL, 16'sd2);

    // pause until the block is empty
    drain();

    // random: mostly well-formed sequences, some noise
    while (items_sent < 1700) begin
      if (items_sent > 1450) quiet_tail = 1;
      if ($urandom_range(0, 3) == 0) write_length(7'(lens[$urandom_range(0, 5)]));
      taps = (sb.length_reg == 0) ? 1 : ((sb.length_reg > 64) ? 64 : sb.length_reg);
      if (taps == 64 && $urandom_range(0, 3) != 0) begin
        write_length(7'($urandom_range(1, 8)));
        taps = sb.length_reg;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 12))
          send_item(func_t'($urandom_range(0, 3)), rand_sample());
      end else begin
        run_sequence(taps - (($urandom_range(0, 5) == 0) ? $urandom_range(0, taps - 1) : 0),
                     taps + $urandom_range(2, 30));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("run covered %0d input items and %0d results over lengths 0 to 127",
             items_sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.exp_coef.size() == 0) begin
      $display("pearson_template_correlator_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.exp_coef.size());
      $display("pearson_template_correlator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #1500000000;
    $display("timeout");
    $display("pearson_template_correlator_core regression: fail");
    $finish;
  end
endmodule
